// ----- hdl/fsfl_pkg.sv -----
// Shared widths, codes and defaults for the fixed-slot free-list allocator.
`timescale 1ns / 1ps
package fsfl_pkg;

   localparam int SIZE_W   = 16;
   localparam int SLOT_W   = 8;
   localparam int STATUS_W = 2;

   localparam int NUM_SLOTS_DEF = 256;

   localparam logic [SIZE_W-1:0] ITEM_SIZE_RST = 16'd16;

   localparam logic KIND_ALLOC = 1'b0;
   localparam logic KIND_FREE  = 1'b1;

   localparam logic [STATUS_W-1:0] STAT_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_MISMATCH  = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_EMPTY     = 2'd2;
   localparam logic [STATUS_W-1:0] STAT_REALLOC   = 2'd3;

   typedef logic [SIZE_W-1:0]   size_type;
   typedef logic [SLOT_W-1:0]   slot_type;
   typedef logic [STATUS_W-1:0] status_type;

endpackage

// ----- hdl/fixed_slot_free_list_allocator_core.sv -----
// An accepted item is registered, executed in the EXEC state and its result registered onto the rsp_ ports,
// strobed for one cycle; the receiver cannot stall it.
// Busy stays high while an item executes, so a new item is not taken until the last one is done.
// Reset (synchronous, active high): item_size returns to 16 and busy stays high while
// the link store is chained slot 0 through the last slot.
`timescale 1ns / 1ps
module fixed_slot_free_list_allocator_core #(
   parameter int NUM_SLOTS = fsfl_pkg::NUM_SLOTS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  logic                 req_kind,
   input  fsfl_pkg::size_type   req_request_size,
   input  fsfl_pkg::slot_type   req_free_slot,
   output logic                 rsp_strobe,
   output fsfl_pkg::status_type rsp_status,
   output fsfl_pkg::slot_type   rsp_granted_slot,
   input  logic                 csr_wr_en,
   input  fsfl_pkg::size_type   csr_wr_data
);
   import fsfl_pkg::*;

   localparam int IDX_W  = $clog2(NUM_SLOTS);
   localparam int LINK_W = $clog2(NUM_SLOTS + 1);

   size_type item_size_ff;

   logic              mem_wr_en;
   logic [IDX_W-1:0]  mem_wr_addr;
   logic [LINK_W-1:0] mem_wr_data;
   logic [IDX_W-1:0]  mem_rd_addr;
   logic [LINK_W-1:0] mem_rd_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         item_size_ff <= ITEM_SIZE_RST;
      end else if (csr_wr_en) begin
         item_size_ff <= csr_wr_data;
      end
   end

   fsfl_engine #(
      .NUM_SLOTS (NUM_SLOTS),
      .IDX_W     (IDX_W),
      .LINK_W    (LINK_W)
   ) u_engine (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .kind             (req_kind),
      .request_size     (req_request_size),
      .free_slot        (req_free_slot),
      .item_size        (item_size_ff),
      .rsp_strobe       (rsp_strobe),
      .rsp_status       (rsp_status),
      .rsp_granted_slot (rsp_granted_slot),
      .mem_wr_en        (mem_wr_en),
      .mem_wr_addr      (mem_wr_addr),
      .mem_wr_data      (mem_wr_data),
      .mem_rd_addr      (mem_rd_addr),
      .mem_rd_data      (mem_rd_data)
   );

   fsfl_link_ram #(
      .DEPTH  (NUM_SLOTS),
      .ADDR_W (IDX_W),
      .DATA_W (LINK_W)
   ) u_link_ram (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

endmodule

// ----- hdl/fsfl_link_ram.sv -----
// Link store: one write port and one registered read port.
`timescale 1ns / 1ps
module fsfl_link_ram #(
   parameter int DEPTH  = 256,
   parameter int ADDR_W = 8,
   parameter int DATA_W = 9
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hdl/fsfl_engine.sv -----
// Request register, link-store init sweep, pop/push logic and result register.
`timescale 1ns / 1ps
module fsfl_engine #(
   parameter int NUM_SLOTS = fsfl_pkg::NUM_SLOTS_DEF,
   parameter int IDX_W     = $clog2(NUM_SLOTS),
   parameter int LINK_W    = $clog2(NUM_SLOTS + 1)
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  logic                 kind,
   input  fsfl_pkg::size_type   request_size,
   input  fsfl_pkg::slot_type   free_slot,
   input  fsfl_pkg::size_type   item_size,
   output logic                 rsp_strobe,
   output fsfl_pkg::status_type rsp_status,
   output fsfl_pkg::slot_type   rsp_granted_slot,
   output logic                 mem_wr_en,
   output logic [IDX_W-1:0]     mem_wr_addr,
   output logic [LINK_W-1:0]    mem_wr_data,
   output logic [IDX_W-1:0]     mem_rd_addr,
   input  logic [LINK_W-1:0]    mem_rd_data
);
   import fsfl_pkg::*;

   localparam logic [1:0] S_INIT = 2'd0;
   localparam logic [1:0] S_IDLE = 2'd1;
   localparam logic [1:0] S_EXEC = 2'd2;

   localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(NUM_SLOTS);
   localparam logic [IDX_W-1:0]  LAST_IDX  = IDX_W'(NUM_SLOTS - 1);

   logic [1:0]        state_ff, state_in;
   logic [IDX_W-1:0]  init_cnt_ff, init_cnt_in;
   logic [LINK_W-1:0] head_ff, head_in;

   logic       kind_ff;
   size_type   size_ff;
   slot_type   slot_ff;

   logic       rsp_strobe_ff, rsp_strobe_in;
   status_type status_ff, status_in;
   slot_type   granted_ff, granted_in;

   logic accept;

   assign busy   = (state_ff != S_IDLE);
   assign accept = start && !busy;

   // The head's link is read every cycle, so it is ready in the cycle after accept.
   assign mem_rd_addr = IDX_W'(head_ff);

   always_comb begin
      state_in      = state_ff;
      init_cnt_in   = init_cnt_ff;
      head_in       = head_ff;
      rsp_strobe_in = 1'b0;
      status_in     = status_ff;
      granted_in    = granted_ff;
      mem_wr_en     = 1'b0;
      mem_wr_addr   = init_cnt_ff;
      mem_wr_data   = LINK_W'(init_cnt_ff) + LINK_W'(1);
      case (state_ff)
         S_INIT: begin
            // Chain entry i to i+1; the last entry gets the null mark.
            mem_wr_en   = 1'b1;
            init_cnt_in = init_cnt_ff + IDX_W'(1);
            if (init_cnt_ff == LAST_IDX) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            state_in      = S_IDLE;
            rsp_strobe_in = 1'b1;
            status_in     = STAT_OK;
            granted_in    = '0;
            if (kind_ff == KIND_FREE) begin
               if (size_ff != '0) begin
                  status_in = STAT_REALLOC;
               end else if (32'(slot_ff) < NUM_SLOTS) begin
                  mem_wr_en   = 1'b1;
                  mem_wr_addr = IDX_W'(slot_ff);
                  mem_wr_data = head_ff;
                  head_in     = LINK_W'(slot_ff);
               end
            end else begin
               if (size_ff != item_size) begin
                  status_in = STAT_MISMATCH;
               end else if (head_ff >= NULL_LINK) begin
                  status_in = STAT_EMPTY;
               end else begin
                  granted_in = SLOT_W'(head_ff);
                  head_in    = mem_rd_data;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_INIT;
         init_cnt_ff   <= '0;
         head_ff       <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         init_cnt_ff   <= init_cnt_in;
         head_ff       <= head_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         kind_ff <= kind;
         size_ff <= request_size;
         slot_ff <= free_slot;
      end
      status_ff  <= status_in;
      granted_ff <= granted_in;
   end

   assign rsp_strobe       = rsp_strobe_ff;
   assign rsp_status       = status_ff;
   assign rsp_granted_slot = granted_ff;

   a_strobe_after_exec: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff |-> $past(state_ff == S_EXEC))
      else $error("result strobe without a preceding execute cycle");

   a_accept_to_exec: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == S_EXEC))
      else $error("accepted item did not enter execute");

   a_head_in_range: assert property (@(posedge clock) disable iff (reset)
      head_ff <= NULL_LINK)
      else $error("free-list head beyond the null mark");

   a_grant_is_old_head: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe_ff && status_ff == STAT_OK && $past(kind_ff) == KIND_ALLOC)
         |-> (granted_ff == SLOT_W'($past(head_ff))))
      else $error("granted slot is not the previous head");

   a_no_strobe_in_init: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_INIT) |-> !rsp_strobe_ff)
      else $error("result strobe during link-store init");

endmodule

// ----- verif/fixed_slot_free_list_allocator_core_test.sv -----
// Self-checking testbench for the fixed-slot free-list allocator core.
`timescale 1ns / 1ps
module fixed_slot_free_list_allocator_core_test;
   import fsfl_pkg::*;

   localparam int NUM_SLOTS   = NUM_SLOTS_DEF;
   localparam int CYCLE_LIMIT = 200000;
   localparam int NUM_PHASES  = 5;

   typedef struct packed {
      status_type status;
      slot_type   slot;
   } grant_type;

   typedef struct packed {
      logic       kind;
      size_type   size;
      slot_type   slot;
      logic       typed;
      status_type status;
      slot_type   granted;
   } directed_row_type;

   logic       clock;
   logic       reset;
   logic       start;
   logic       busy;
   logic       req_kind;
   size_type   req_request_size;
   slot_type   req_free_slot;
   logic       rsp_strobe;
   status_type rsp_status;
   slot_type   rsp_granted_slot;
   logic       csr_wr_en;
   size_type   csr_wr_data;

   // Shadow copy of the pool: link entries are one bit wider than a slot index
   // so that the null mark (NUM_SLOTS) fits.
   logic [SLOT_W:0] link_ram [NUM_SLOTS];
   logic [SLOT_W:0] head_slot;
   size_type        item_size_model;

   grant_type pending_grants [$];
   slot_type  held_slots [$];
   int        mismatch_count;
   int        cycle_count = 0;
   int        burst_left;

   // Rows marked typed carry a result that follows directly from the reset chain.
   directed_row_type directed_rows [0:20] = '{
      '{KIND_ALLOC, 16'd16,    8'hFF, 1'b1, STAT_OK,       8'd0},
      '{KIND_ALLOC, 16'd16,    8'h00, 1'b1, STAT_OK,       8'd1},
      '{KIND_ALLOC, 16'd15,    8'h00, 1'b1, STAT_MISMATCH, 8'd0},
      '{KIND_ALLOC, 16'd0,     8'h00, 1'b1, STAT_MISMATCH, 8'd0},
      '{KIND_ALLOC, 16'hFFFF,  8'hFF, 1'b1, STAT_MISMATCH, 8'd0},
      '{KIND_ALLOC, 16'd17,    8'h00, 1'b1, STAT_MISMATCH, 8'd0},
      '{KIND_FREE,  16'd1,     8'h00, 1'b1, STAT_REALLOC,  8'd0},
      '{KIND_FREE,  16'hFFFF,  8'hFF, 1'b1, STAT_REALLOC,  8'd0},
      '{KIND_FREE,  16'h8000,  8'h80, 1'b1, STAT_REALLOC,  8'd0},
      '{KIND_FREE,  16'd0,     8'h00, 1'b1, STAT_OK,       8'd0},
      '{KIND_ALLOC, 16'd16,    8'h00, 1'b1, STAT_OK,       8'd0},
      '{KIND_FREE,  16'd0,     8'h01, 1'b1, STAT_OK,       8'd0},
      '{KIND_FREE,  16'd0,     8'h00, 1'b1, STAT_OK,       8'd0},
      '{KIND_ALLOC, 16'd16,    8'h00, 1'b0, STAT_OK,       8'd0},
      '{KIND_ALLOC, 16'd16,    8'h00, 1'b0, STAT_OK,       8'd0},
      '{KIND_ALLOC, 16'd16,    8'h00, 1'b0, STAT_OK,       8'd0},
      '{KIND_ALLOC, 16'd16,    8'hAA, 1'b0, STAT_OK,       8'd0},
      '{KIND_FREE,  16'd0,     8'h03, 1'b0, STAT_OK,       8'd0},
      '{KIND_FREE,  16'd0,     8'h02, 1'b0, STAT_OK,       8'd0},
      '{KIND_FREE,  16'd0,     8'h01, 1'b0, STAT_OK,       8'd0},
      '{KIND_FREE,  16'd0,     8'h00, 1'b0, STAT_OK,       8'd0}
   };

   fixed_slot_free_list_allocator_core dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_kind         (req_kind),
      .req_request_size (req_request_size),
      .req_free_slot    (req_free_slot),
      .rsp_strobe       (rsp_strobe),
      .rsp_status       (rsp_status),
      .rsp_granted_slot (rsp_granted_slot),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data)
   );

   initial clock = 1'b0;
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   task automatic flag_mismatch(input string what, input int got, input int want);
      $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
      mismatch_count++;
   endtask

   // Pops or pushes the shadow pool exactly as the block does for one item,
   // and keeps the list of slots the testbench currently owns.
   function automatic grant_type pool_request(input logic kind, input size_type size,
                                              input slot_type slot);
      grant_type r;
      int        i;
      r.status = STAT_OK;
      r.slot   = '0;
      if (kind == KIND_FREE) begin
         if (size != 0) begin
            r.status = STAT_REALLOC;
         end else if ({1'b0, slot} < NUM_SLOTS) begin
            link_ram[slot] = head_slot;
            head_slot      = {1'b0, slot};
            for (i = 0; i < held_slots.size(); i++) begin
               if (held_slots[i] == slot) begin
                  held_slots.delete(i);
                  break;
               end
            end
         end
      end else begin
         if (size != item_size_model) begin
            r.status = STAT_MISMATCH;
         end else if (head_slot >= NUM_SLOTS) begin
            r.status = STAT_EMPTY;
         end else begin
            r.slot    = head_slot[SLOT_W-1:0];
            head_slot = link_ram[head_slot];
            held_slots.push_back(r.slot);
         end
      end
      return r;
   endfunction

   task automatic issue_request(input logic kind, input size_type size, input slot_type slot,
                                input logic typed, input status_type want_status,
                                input slot_type want_slot);
      grant_type r;
      req_kind         <= kind;
      req_request_size <= size;
      req_free_slot    <= slot;
      start            <= 1'b1;
      @(posedge clock);
      while (busy !== 1'b0) @(posedge clock);
      r = pool_request(kind, size, slot);
      if (typed) begin
         r.status = want_status;
         r.slot   = want_slot;
      end
      pending_grants.push_back(r);
   endtask

   // Bursts of back-to-back items separated by idle gaps of random length.
   task automatic pace_sender();
      int gap;
      if (burst_left == 0) begin
         gap   = $urandom_range(1, 10);
         start <= 1'b0;
         repeat (gap) @(posedge clock);
         if ($urandom_range(0, 9) == 0) burst_left = $urandom_range(60, 150);
         else burst_left = $urandom_range(1, 24);
      end
      burst_left--;
   endtask

   task automatic wait_drained();
      start <= 1'b0;
      while (pending_grants.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic write_item_size(input size_type value);
      wait_drained();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en       <= 1'b0;
      item_size_model  = value;
   endtask

   always @(posedge clock) begin
      grant_type want;
      if (!reset && rsp_strobe === 1'b1) begin
         if (pending_grants.size() == 0) begin
            flag_mismatch("result with nothing pending", rsp_status, 0);
         end else begin
            want = pending_grants.pop_front();
            if (rsp_status !== want.status)
               flag_mismatch("status", rsp_status, want.status);
            if (rsp_granted_slot !== want.slot)
               flag_mismatch("granted_slot", rsp_granted_slot, want.slot);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("** fixed_slot_free_list_allocator_core: FAILED **");
         $finish;
      end
   end

   initial begin
      // Per phase: item size (0 picks one at random), item count, allocate share
      // in percent, and the percentage of items that are frees of an arbitrary slot.
      int         phase_size  [NUM_PHASES];
      int         phase_items [NUM_PHASES];
      int         phase_bias  [NUM_PHASES];
      int         phase_stray [NUM_PHASES];
      int         p;
      int         i;
      int         r;
      logic       kind;
      size_type   size;
      slot_type   slot;
      size_type   next_size;

      phase_size  = '{65535, 1, 0, 16, 0};
      phase_items = '{400, 300, 300, 300, 330};
      phase_bias  = '{95, 20, 60, 75, 50};
      phase_stray = '{0, 0, 0, 0, 8};

      mismatch_count   = 0;
      burst_left       = 0;
      item_size_model  = ITEM_SIZE_RST;
      for (i = 0; i < NUM_SLOTS; i++) link_ram[i] = (SLOT_W + 1)'(i + 1);
      head_slot = '0;

      reset            <= 1'b1;
      start            <= 1'b0;
      req_kind         <= KIND_ALLOC;
      req_request_size <= '0;
      req_free_slot    <= '0;
      csr_wr_en        <= 1'b0;
      csr_wr_data      <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // The link store is chained during the clearing pass; busy covers it.
      while (busy !== 1'b0) @(posedge clock);

      for (i = 0; i < $size(directed_rows); i++) begin
         pace_sender();
         issue_request(directed_rows[i].kind, directed_rows[i].size, directed_rows[i].slot,
                       directed_rows[i].typed, directed_rows[i].status,
                       directed_rows[i].granted);
      end

      // Frees of arbitrary slots corrupt the chain into a loop, so they only
      // appear in the last phase, after the pool has been run empty.
      for (p = 0; p < NUM_PHASES; p++) begin
         if (phase_size[p] == 0) next_size = size_type'($urandom_range(2, 65534));
         else next_size = size_type'(phase_size[p]);
         write_item_size(next_size);
         for (i = 0; i < phase_items[p]; i++) begin
            r    = $urandom_range(0, 99);
            slot = slot_type'($urandom_range(0, 255));
            if (r < 5) begin
               kind = KIND_ALLOC;
               size = size_type'($urandom_range(0, 65535));
            end else if (r < 9) begin
               kind = KIND_FREE;
               size = size_type'($urandom_range(1, 65535));
            end else if (r < 9 + phase_stray[p]) begin
               kind = KIND_FREE;
               size = '0;
            end else if (held_slots.size() == 0 ||
                         $urandom_range(0, 99) < phase_bias[p]) begin
               kind = KIND_ALLOC;
               size = item_size_model;
            end else begin
               kind = KIND_FREE;
               size = '0;
               slot = held_slots[$urandom_range(0, held_slots.size() - 1)];
            end
            pace_sender();
            issue_request(kind, size, slot, 1'b0, STAT_OK, '0);
         end
      end

      wait_drained();
      if (mismatch_count == 0) begin
         $display("** fixed_slot_free_list_allocator_core: PASSED **");
      end else begin
         $display("** fixed_slot_free_list_allocator_core: FAILED **");
      end
      $finish;
   end

endmodule
